### src/thw_pkg.sv
`default_nettype none
package thw_pkg;

  localparam int WINDOW_DEF = 10;

  localparam logic [7:0] UPPER_RST    = 8'd75;
  localparam logic [7:0] LOWER_RST    = 8'd35;
  localparam logic [7:0] SETPOINT_RST = 8'd60;
  localparam logic [7:0] READING_RST  = 8'd60;
  localparam logic [4:0] STEP_RST     = 5'd5;
  localparam logic [4:0] MARGIN_RST   = 5'd5;
  localparam logic [3:0] SETLEN_RST   = 4'd5;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETLEN = 3'd4;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RAISE = 2'd1;
  localparam logic [1:0] CMD_LOWER = 2'd2;
  localparam logic [1:0] CMD_POWER = 2'd3;

  // bit-serial divide: quotient is one byte
  localparam logic [2:0] DIV_LAST = 3'd7;

  localparam int UPC_W = 3;
  localparam logic [UPC_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [UPC_W-1:0] ST_DISPATCH = 3'd1;
  localparam logic [UPC_W-1:0] ST_RD_FIRST = 3'd2;
  localparam logic [UPC_W-1:0] ST_SUM      = 3'd3;
  localparam logic [UPC_W-1:0] ST_DIV_INIT = 3'd4;
  localparam logic [UPC_W-1:0] ST_DIV      = 3'd5;
  localparam logic [UPC_W-1:0] ST_COMPARE  = 3'd6;
  localparam logic [UPC_W-1:0] ST_EMIT     = 3'd7;

  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_NO_IN    = 3'd1;
  localparam logic [2:0] COND_NO_STORE = 3'd2;
  localparam logic [2:0] COND_SUM_MORE = 3'd3;
  localparam logic [2:0] COND_DIV_MORE = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY = 3'd5;

  typedef struct packed {
    logic             accept;
    logic             dispatch;
    logic             rd_first;
    logic             sum_loop;
    logic             div_init;
    logic             div_step;
    logic             compare;
    logic             emit;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  function automatic ucw_t ucode(input logic [UPC_W-1:0] pc);
    ucw_t w;
    w = '0;
    case (pc)
      ST_IDLE: begin
        w.accept = 1'b1; w.cond = COND_NO_IN; w.target = ST_IDLE;
      end
      ST_DISPATCH: begin
        w.dispatch = 1'b1; w.cond = COND_NO_STORE; w.target = ST_EMIT;
      end
      ST_RD_FIRST: begin
        w.rd_first = 1'b1; w.cond = COND_NONE; w.target = ST_IDLE;
      end
      ST_SUM: begin
        w.sum_loop = 1'b1; w.cond = COND_SUM_MORE; w.target = ST_SUM;
      end
      ST_DIV_INIT: begin
        w.div_init = 1'b1; w.cond = COND_NONE; w.target = ST_IDLE;
      end
      ST_DIV: begin
        w.div_step = 1'b1; w.cond = COND_DIV_MORE; w.target = ST_DIV;
      end
      ST_COMPARE: begin
        w.compare = 1'b1; w.cond = COND_NONE; w.target = ST_IDLE;
      end
      ST_EMIT: begin
        w.emit = 1'b1; w.cond = COND_OUT_BUSY; w.target = ST_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### src/thermostat_with_averaging.sv
`default_nettype none
// Bang-bang thermostat with a sliding-window average of the last WINDOW readings.
// One transaction in (command, sample) gives exactly one transaction out. For a tick
// that stores a reading, the sum walks the history memory one entry a cycle and the
// mean comes from an eight-step bit-serial divider before the compare and the emit.
// Presses, power toggles and ticks that store nothing go from dispatch straight to
// emit. One event is worked at a time; a finished result waits in the output register
// while the next event is accepted, and the next result waits until that one is
// taken. Configuration writes are taken every cycle.
module thermostat_with_averaging
  import thw_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           command,
  input  wire logic [7:0]           sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      heater_on,
  output logic                      cooler_on,
  output logic                      system_on,
  output logic                      in_set_mode,
  output logic [7:0]                display_value,
  output logic [7:0]                average_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW     = $clog2(WINDOW + 1);
  localparam int SW_RAW = $clog2(WINDOW * 255 + 1);
  localparam int SW     = (SW_RAW > 9) ? SW_RAW : 9;
  localparam int RW     = FW + 1;

  logic [7:0] upper_limit, lower_limit;
  logic [4:0] setpoint_step, band_margin;
  logic [3:0] set_mode_length;

  logic [UPC_W-1:0] pc, pc_next;
  ucw_t             cw;
  logic             take;

  logic [7:0]    high_sp, low_sp, latest, avg;
  logic          power_on, heater, cooler;
  logic [3:0]    set_ticks;
  logic [AW-1:0] slot;
  logic [FW-1:0] fill, k;
  logic [2:0]    dcnt;

  logic [1:0]    cmd;
  logic [7:0]    smp, disp, disp_next, rdata, q;
  logic [SW-1:0] acc;
  logic [RW-1:0] rem, rem_sh;
  logic          ge;
  logic [7:0]    mem [WINDOW];

  logic       store, raise_ok, lower_ok, rd_en, out_busy, cool_cond, heat_cond;
  logic [8:0] raise_sum, floor_v;
  logic [7:0] raise_val, lower_val;

  assign cw        = ucode(pc);
  assign in_ready  = cw.accept;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && !out_ready;

  assign store     = (cmd == CMD_TICK) && power_on && (set_ticks == 4'd0);
  assign raise_ok  = power_on && (high_sp < upper_limit);
  assign lower_ok  = power_on && (low_sp > lower_limit);
  assign raise_sum = {1'b0, high_sp} + 9'(setpoint_step);
  assign raise_val = (raise_sum > {1'b0, upper_limit}) ? upper_limit : raise_sum[7:0];
  assign floor_v   = {1'b0, lower_limit} + 9'(setpoint_step);
  assign lower_val = ({1'b0, low_sp} < floor_v) ? lower_limit : low_sp - 8'(setpoint_step);

  assign rd_en  = cw.rd_first || (cw.sum_loop && (k != fill));
  assign rem_sh = {rem[FW-1:0], q[7]};
  assign ge     = rem_sh >= RW'(fill);

  assign cool_cond = {1'b0, q} > ({1'b0, high_sp} + 9'(band_margin));
  assign heat_cond = ({1'b0, q} + 9'(band_margin)) < {1'b0, low_sp};

  always_comb begin
    case (cmd)
      CMD_RAISE: disp_next = raise_ok ? raise_val : high_sp;
      CMD_LOWER: disp_next = lower_ok ? lower_val : low_sp;
      CMD_TICK:  disp_next = store ? smp : latest;
      default:   disp_next = latest;
    endcase
  end

  always_comb begin
    case (cw.cond)
      COND_NO_IN:    take = !in_valid;
      COND_NO_STORE: take = !store;
      COND_SUM_MORE: take = k != fill;
      COND_DIV_MORE: take = dcnt != 3'd0;
      COND_OUT_BUSY: take = out_busy;
      default:       take = 1'b0;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= ST_IDLE;
      upper_limit     <= UPPER_RST;
      lower_limit     <= LOWER_RST;
      setpoint_step   <= STEP_RST;
      band_margin     <= MARGIN_RST;
      set_mode_length <= SETLEN_RST;
      high_sp         <= SETPOINT_RST;
      low_sp          <= SETPOINT_RST;
      power_on        <= 1'b0;
      set_ticks       <= 4'd0;
      slot            <= '0;
      fill            <= '0;
      latest          <= READING_RST;
      heater          <= 1'b0;
      cooler          <= 1'b0;
      avg             <= 8'd0;
      k               <= '0;
      dcnt            <= 3'd0;
      out_valid       <= 1'b0;
    end else begin
      pc <= pc_next;

      if (cfg_valid) begin
        case (cfg_index)
          REG_UPPER:  upper_limit     <= cfg_data;
          REG_LOWER:  lower_limit     <= cfg_data;
          REG_STEP:   setpoint_step   <= cfg_data[4:0];
          REG_MARGIN: band_margin     <= cfg_data[4:0];
          REG_SETLEN: set_mode_length <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (cw.dispatch) begin
        k <= '0;
        case (cmd)
          CMD_RAISE: begin
            if (raise_ok) begin
              high_sp   <= raise_val;
              set_ticks <= set_mode_length;
            end
          end
          CMD_LOWER: begin
            if (lower_ok) begin
              low_sp    <= lower_val;
              set_ticks <= set_mode_length;
            end
          end
          CMD_POWER: begin
            if (power_on) begin
              power_on  <= 1'b0;
              heater    <= 1'b0;
              cooler    <= 1'b0;
              set_ticks <= 4'd0;
            end else begin
              power_on <= 1'b1;
            end
          end
          default: begin
            if (power_on && (set_ticks != 4'd0)) begin
              set_ticks <= set_ticks - 4'd1;
            end else if (store) begin
              latest <= smp;
              slot   <= (slot == AW'(WINDOW - 1)) ? '0 : slot + 1'b1;
              if (fill < FW'(WINDOW)) fill <= fill + 1'b1;
            end
          end
        endcase
      end

      if (rd_en) k <= k + 1'b1;
      if (cw.div_init) dcnt <= DIV_LAST;
      if (cw.div_step) dcnt <= dcnt - 3'd1;

      if (cw.compare) begin
        avg    <= q;
        cooler <= cool_cond;
        heater <= !cool_cond && heat_cond;
      end

      if (cw.emit && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.accept && in_valid) begin
      cmd <= command;
      smp <= sample;
    end
    if (cw.dispatch) begin
      disp <= disp_next;
      acc  <= '0;
      if (store) mem[slot] <= smp;
    end
    if (rd_en) rdata <= mem[k[AW-1:0]];
    if (cw.sum_loop) acc <= acc + SW'(rdata);
    if (cw.div_init) begin
      rem <= RW'(acc >> 8);
      q   <= acc[7:0];
    end
    if (cw.div_step) begin
      rem <= ge ? rem_sh - RW'(fill) : rem_sh;
      q   <= {q[6:0], ge};
    end
    if (cw.emit && !out_busy) begin
      heater_on     <= heater;
      cooler_on     <= cooler;
      system_on     <= power_on;
      in_set_mode   <= set_ticks != 4'd0;
      display_value <= disp;
      average_value <= avg;
    end
  end

endmodule
`default_nettype wire

### src/thw_checker.sv
`default_nettype none
module thw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       heater_on,
  input wire logic       cooler_on,
  input wire logic       system_on,
  input wire logic       in_set_mode,
  input wire logic [7:0] display_value,
  input wire logic [7:0] average_value
);

  a_drives_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(heater_on && cooler_on))
    else $error("heater and cooler driven together");

  a_off_no_drive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !system_on) |-> (!heater_on && !cooler_on))
    else $error("drive active while powered off");

  a_set_mode_needs_power: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_set_mode) |-> system_on)
    else $error("set mode while powered off");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(display_value) && $stable(average_value)))
    else $error("stalled output transaction changed");

endmodule

bind thermostat_with_averaging thw_checker u_thw_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .heater_on     (heater_on),
  .cooler_on     (cooler_on),
  .system_on     (system_on),
  .in_set_mode   (in_set_mode),
  .display_value (display_value),
  .average_value (average_value)
);
`default_nettype wire
